// ===== rtl/core/owm_pkg.sv =====
// Shared types, register indexes, command codes and timing helpers for the
// one-wire bus master. Every other file of the block uses this package.
// Depends on nothing.
package owm_pkg;

  // Width of the phase timer; every phase length saturates at 2^TIMER_BITS - 1.
  localparam int TIMER_BITS = 20;
  // Width of the configuration data bus (widest register).
  localparam int CFG_W      = 20;
  localparam int CFG_IDX_W  = 3;
  localparam int IN_W       = 16;
  localparam int OUT_W      = 32;

  typedef logic [TIMER_BITS-1:0] timer_t;

  // Configuration register indexes.
  localparam logic [CFG_IDX_W-1:0] REG_RESET_LOW      = 3'd0;
  localparam logic [CFG_IDX_W-1:0] REG_PRESENCE_WAIT  = 3'd1;
  localparam logic [CFG_IDX_W-1:0] REG_RESET_RECOVERY = 3'd2;
  localparam logic [CFG_IDX_W-1:0] REG_WRITE_ONE_LOW  = 3'd3;
  localparam logic [CFG_IDX_W-1:0] REG_SLOT           = 3'd4;
  localparam logic [CFG_IDX_W-1:0] REG_READ_LOW       = 3'd5;
  localparam logic [CFG_IDX_W-1:0] REG_CONVERT_WAIT   = 3'd6;

  // Command codes.
  localparam logic [2:0] CMD_NONE    = 3'd0;
  localparam logic [2:0] CMD_RESET   = 3'd1;
  localparam logic [2:0] CMD_WRITE   = 3'd2;
  localparam logic [2:0] CMD_READ    = 3'd3;
  localparam logic [2:0] CMD_MEASURE = 3'd4;

  // Steps of the measure sequence.
  localparam logic [3:0] STEP_RESET_A    = 4'd0;
  localparam logic [3:0] STEP_SKIP_A     = 4'd1;
  localparam logic [3:0] STEP_CONVERT    = 4'd2;
  localparam logic [3:0] STEP_WAIT       = 4'd3;
  localparam logic [3:0] STEP_RESET_B    = 4'd4;
  localparam logic [3:0] STEP_SKIP_B     = 4'd5;
  localparam logic [3:0] STEP_READ_SCR   = 4'd6;
  localparam logic [3:0] STEP_READ_LSB   = 4'd7;
  localparam logic [3:0] STEP_READ_MSB   = 4'd8;

  // Bus command bytes sent by the measure sequence.
  localparam logic [7:0] ROM_SKIP        = 8'hCC;
  localparam logic [7:0] CONVERT_T       = 8'h44;
  localparam logic [7:0] READ_SCRATCHPAD = 8'hBE;

  typedef enum logic [8:0] {
    PH_IDLE     = 9'b000000001,
    PH_RST_LOW  = 9'b000000010,
    PH_RST_WAIT = 9'b000000100,
    PH_RST_REC  = 9'b000001000,
    PH_WR_LOW   = 9'b000010000,
    PH_WR_REL   = 9'b000100000,
    PH_RD_LOW   = 9'b001000000,
    PH_RD_REC   = 9'b010000000,
    PH_CONV     = 9'b100000000
  } phase_t;

  typedef struct packed {
    logic [9:0]  reset_low_ticks;
    logic [9:0]  presence_wait_ticks;
    logic [9:0]  reset_recovery_ticks;
    logic [5:0]  write_one_low_ticks;
    logic [9:0]  slot_ticks;
    logic [5:0]  read_low_ticks;
    logic [19:0] convert_wait_ticks;
  } cfg_t;

  typedef struct packed {
    logic [2:0] cmd;
    logic [7:0] tx_byte;
    logic       line_level;
  } in_item_t;

  typedef struct packed {
    logic        drive_low;
    logic        busy_res;
    logic        done_res;
    logic        presence;
    logic [7:0]  rx_byte;
    logic [15:0] temperature_raw;
  } out_item_t;

  localparam logic [CFG_W+TIMER_BITS-1:0] TIMER_MAX_W =
    {{CFG_W{1'b0}}, {TIMER_BITS{1'b1}}};

  // Phase length from a register value: optionally at least one tick,
  // saturated to the timer range.
  function automatic timer_t len_of(input logic [CFG_W-1:0] v, input logic min_one);
    logic [CFG_W+TIMER_BITS-1:0] w;
    w = {{TIMER_BITS{1'b0}}, v};
    if (min_one && (v == '0)) begin
      w = {{(CFG_W+TIMER_BITS-1){1'b0}}, 1'b1};
    end
    if (w > TIMER_MAX_W) begin
      w = TIMER_MAX_W;
    end
    return w[TIMER_BITS-1:0];
  endfunction

endpackage

// ===== rtl/core/owm_cfg_regs.sv =====
// Configuration register file of the one-wire bus master.
// Depends on owm_pkg for the register indexes and the cfg_t layout.
module owm_cfg_regs (
  input  logic                          clk,
  input  logic                          rst,
  input  logic                          wr_en,
  input  logic [owm_pkg::CFG_IDX_W-1:0] wr_index,
  input  logic [owm_pkg::CFG_W-1:0]     wr_data,
  output owm_pkg::cfg_t                 cfg
);

  always_ff @(posedge clk) begin
    if (rst) begin
      cfg.reset_low_ticks      <= 10'd480;
      cfg.presence_wait_ticks  <= 10'd80;
      cfg.reset_recovery_ticks <= 10'd400;
      cfg.write_one_low_ticks  <= 6'd1;
      cfg.slot_ticks           <= 10'd60;
      cfg.read_low_ticks       <= 6'd2;
      cfg.convert_wait_ticks   <= 20'd200000;
    end else if (wr_en) begin
      // Indexes beyond the list are dropped.
      unique case (wr_index)
        owm_pkg::REG_RESET_LOW:      cfg.reset_low_ticks      <= wr_data[9:0];
        owm_pkg::REG_PRESENCE_WAIT:  cfg.presence_wait_ticks  <= wr_data[9:0];
        owm_pkg::REG_RESET_RECOVERY: cfg.reset_recovery_ticks <= wr_data[9:0];
        owm_pkg::REG_WRITE_ONE_LOW:  cfg.write_one_low_ticks  <= wr_data[5:0];
        owm_pkg::REG_SLOT:           cfg.slot_ticks           <= wr_data[9:0];
        owm_pkg::REG_READ_LOW:       cfg.read_low_ticks       <= wr_data[5:0];
        owm_pkg::REG_CONVERT_WAIT:   cfg.convert_wait_ticks   <= wr_data[19:0];
        default: ;
      endcase
    end
  end

endmodule

// ===== rtl/core/owm_step.sv =====
// Bus sequencer of the one-wire master: holds the phase state and works out
// one tick's result from the registered tick. Depends on owm_pkg.
module owm_step (
  input  logic               clk,
  input  logic               rst,
  input  logic               fire,
  input  owm_pkg::in_item_t  tick,
  input  owm_pkg::cfg_t      cfg,
  output owm_pkg::out_item_t result
);

  owm_pkg::phase_t phase, phase_next;
  owm_pkg::timer_t tick_count, tick_count_next;
  logic [2:0]  bit_index, bit_index_next;
  logic [7:0]  shift_byte, shift_byte_next;
  logic [3:0]  sequence_step, sequence_step_next;
  logic [15:0] word_accumulator, word_accumulator_next;
  logic        presence_flag, presence_flag_next;
  logic [2:0]  command_kind, command_kind_next;
  logic [7:0]  rx_latch, rx_latch_next;
  logic [15:0] temp_latch, temp_latch_next;

  owm_pkg::timer_t len_rst_low, len_pres, len_rec, len_one, len_slot, len_rd, len_conv;

  always_comb begin
    len_rst_low = owm_pkg::len_of(owm_pkg::CFG_W'(cfg.reset_low_ticks), 1'b1);
    len_pres    = owm_pkg::len_of(owm_pkg::CFG_W'(cfg.presence_wait_ticks), 1'b1);
    len_rec     = owm_pkg::len_of(owm_pkg::CFG_W'(cfg.reset_recovery_ticks), 1'b0);
    len_one     = owm_pkg::len_of(owm_pkg::CFG_W'(cfg.write_one_low_ticks), 1'b1);
    len_slot    = owm_pkg::len_of(owm_pkg::CFG_W'(cfg.slot_ticks), 1'b1);
    len_rd      = owm_pkg::len_of(owm_pkg::CFG_W'(cfg.read_low_ticks), 1'b1);
    len_conv    = owm_pkg::len_of(owm_pkg::CFG_W'(cfg.convert_wait_ticks), 1'b0);
  end

  logic       prim_end;
  logic       done;
  logic       busy;
  logic       drive;
  logic       cur_bit;
  logic [3:0] step_sel;

  always_comb begin
    phase_next            = phase;
    tick_count_next       = tick_count;
    bit_index_next        = bit_index;
    shift_byte_next       = shift_byte;
    sequence_step_next    = sequence_step;
    word_accumulator_next = word_accumulator;
    presence_flag_next    = presence_flag;
    command_kind_next     = command_kind;
    rx_latch_next         = rx_latch;
    temp_latch_next       = temp_latch;
    prim_end              = 1'b0;
    done                  = 1'b0;
    step_sel              = '0;

    // A command is taken only on an idle tick and acts on that same tick.
    if ((phase == owm_pkg::PH_IDLE) && (tick.cmd >= owm_pkg::CMD_RESET) &&
        (tick.cmd <= owm_pkg::CMD_MEASURE)) begin
      command_kind_next  = tick.cmd;
      sequence_step_next = owm_pkg::STEP_RESET_A;
      tick_count_next    = '0;
      bit_index_next     = '0;
      if ((tick.cmd == owm_pkg::CMD_RESET) || (tick.cmd == owm_pkg::CMD_MEASURE)) begin
        presence_flag_next = 1'b1;
      end
      unique case (tick.cmd)
        owm_pkg::CMD_WRITE: begin
          shift_byte_next = tick.tx_byte;
          phase_next      = owm_pkg::PH_WR_LOW;
        end
        owm_pkg::CMD_READ: begin
          shift_byte_next = '0;
          phase_next      = owm_pkg::PH_RD_LOW;
        end
        owm_pkg::CMD_MEASURE: begin
          word_accumulator_next = '0;
          phase_next            = owm_pkg::PH_RST_LOW;
        end
        default: begin
          phase_next = owm_pkg::PH_RST_LOW;
        end
      endcase
    end

    busy    = (phase_next != owm_pkg::PH_IDLE);
    drive   = (phase_next == owm_pkg::PH_RST_LOW) || (phase_next == owm_pkg::PH_WR_LOW) ||
              (phase_next == owm_pkg::PH_RD_LOW);
    cur_bit = shift_byte_next[0];

    if (busy) begin
      tick_count_next = tick_count_next + owm_pkg::timer_t'(1);
    end

    unique case (phase_next)
      owm_pkg::PH_RST_LOW: begin
        if (tick_count_next >= len_rst_low) begin
          phase_next      = owm_pkg::PH_RST_WAIT;
          tick_count_next = '0;
        end
      end
      owm_pkg::PH_RST_WAIT: begin
        if (tick_count_next >= len_pres) begin
          if (tick.line_level) begin
            presence_flag_next = 1'b0;
          end
          if (len_rec == '0) begin
            prim_end = 1'b1;
          end else begin
            phase_next      = owm_pkg::PH_RST_REC;
            tick_count_next = '0;
          end
        end
      end
      owm_pkg::PH_RST_REC: begin
        if (tick_count_next >= len_rec) begin
          prim_end = 1'b1;
        end
      end
      owm_pkg::PH_WR_LOW: begin
        if (tick_count_next >= (cur_bit ? len_one : len_slot)) begin
          phase_next      = owm_pkg::PH_WR_REL;
          tick_count_next = '0;
        end
      end
      owm_pkg::PH_WR_REL: begin
        if (tick_count_next >= (cur_bit ? len_slot : owm_pkg::timer_t'(1))) begin
          shift_byte_next = {1'b0, shift_byte_next[7:1]};
          if (bit_index_next == 3'd7) begin
            prim_end = 1'b1;
          end else begin
            bit_index_next  = bit_index_next + 3'd1;
            phase_next      = owm_pkg::PH_WR_LOW;
            tick_count_next = '0;
          end
        end
      end
      owm_pkg::PH_RD_LOW: begin
        if (tick_count_next >= len_rd) begin
          phase_next      = owm_pkg::PH_RD_REC;
          tick_count_next = '0;
        end
      end
      owm_pkg::PH_RD_REC: begin
        // Sample on the first released tick of the slot.
        if ((tick_count_next == owm_pkg::timer_t'(1)) && tick.line_level) begin
          shift_byte_next[bit_index_next] = 1'b1;
        end
        if (tick_count_next >= len_slot) begin
          if (bit_index_next == 3'd7) begin
            prim_end = 1'b1;
          end else begin
            bit_index_next  = bit_index_next + 3'd1;
            phase_next      = owm_pkg::PH_RD_LOW;
            tick_count_next = '0;
          end
        end
      end
      owm_pkg::PH_CONV: begin
        if (tick_count_next >= len_conv) begin
          prim_end = 1'b1;
        end
      end
      default: begin
        phase_next      = owm_pkg::PH_IDLE;
        tick_count_next = '0;
      end
    endcase

    // End of a bus primitive: either launch the next measure step or finish.
    if (prim_end) begin
      if (command_kind_next == owm_pkg::CMD_MEASURE) begin
        if (sequence_step_next == owm_pkg::STEP_READ_LSB) begin
          word_accumulator_next = {8'd0, shift_byte_next};
        end else if (sequence_step_next == owm_pkg::STEP_READ_MSB) begin
          word_accumulator_next = word_accumulator_next | {shift_byte_next, 8'd0};
          temp_latch_next       = word_accumulator_next;
        end
        step_sel = sequence_step_next + 4'd1;
        if (step_sel <= owm_pkg::STEP_READ_MSB) begin
          if ((step_sel == owm_pkg::STEP_WAIT) && (len_conv == '0)) begin
            step_sel = owm_pkg::STEP_RESET_B;
          end
          sequence_step_next = step_sel;
          tick_count_next    = '0;
          bit_index_next     = '0;
          unique case (step_sel)
            owm_pkg::STEP_RESET_A, owm_pkg::STEP_RESET_B: begin
              phase_next = owm_pkg::PH_RST_LOW;
            end
            owm_pkg::STEP_SKIP_A, owm_pkg::STEP_SKIP_B: begin
              shift_byte_next = owm_pkg::ROM_SKIP;
              phase_next      = owm_pkg::PH_WR_LOW;
            end
            owm_pkg::STEP_CONVERT: begin
              shift_byte_next = owm_pkg::CONVERT_T;
              phase_next      = owm_pkg::PH_WR_LOW;
            end
            owm_pkg::STEP_WAIT: begin
              phase_next = owm_pkg::PH_CONV;
            end
            owm_pkg::STEP_READ_SCR: begin
              shift_byte_next = owm_pkg::READ_SCRATCHPAD;
              phase_next      = owm_pkg::PH_WR_LOW;
            end
            default: begin
              shift_byte_next = '0;
              phase_next      = owm_pkg::PH_RD_LOW;
            end
          endcase
        end else begin
          sequence_step_next = '0;
          phase_next         = owm_pkg::PH_IDLE;
          tick_count_next    = '0;
          done               = 1'b1;
        end
      end else begin
        if (command_kind_next == owm_pkg::CMD_READ) begin
          rx_latch_next = shift_byte_next;
        end
        sequence_step_next = '0;
        phase_next         = owm_pkg::PH_IDLE;
        tick_count_next    = '0;
        done               = 1'b1;
      end
    end

    result.drive_low       = drive;
    result.busy_res        = busy;
    result.done_res        = done;
    result.presence        = presence_flag_next;
    result.rx_byte         = rx_latch_next;
    result.temperature_raw = temp_latch_next;
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      phase            <= owm_pkg::PH_IDLE;
      tick_count       <= '0;
      bit_index        <= '0;
      shift_byte       <= '0;
      sequence_step    <= '0;
      word_accumulator <= '0;
      presence_flag    <= 1'b0;
      command_kind     <= owm_pkg::CMD_NONE;
      rx_latch         <= '0;
      temp_latch       <= '0;
    end else if (fire) begin
      phase            <= phase_next;
      tick_count       <= tick_count_next;
      bit_index        <= bit_index_next;
      shift_byte       <= shift_byte_next;
      sequence_step    <= sequence_step_next;
      word_accumulator <= word_accumulator_next;
      presence_flag    <= presence_flag_next;
      command_kind     <= command_kind_next;
      rx_latch         <= rx_latch_next;
      temp_latch       <= temp_latch_next;
    end
  end

endmodule

// ===== rtl/core/owm_out_buf.sv =====
// Two-entry result queue that parts the sequencer from the output channel.
// Depends on owm_pkg for the result layout.
module owm_out_buf (
  input  logic               clk,
  input  logic               rst,
  input  logic               push,
  input  owm_pkg::out_item_t push_item,
  output logic               full,
  output logic               valid,
  input  logic               ready,
  output owm_pkg::out_item_t head
);

  owm_pkg::out_item_t entry [2];
  logic       wr_ptr;
  logic       rd_ptr;
  logic [1:0] count;
  logic       pop;

  assign pop   = valid && ready;
  assign valid = (count != 2'd0);
  assign full  = (count == 2'd2);
  assign head  = entry[rd_ptr];

  always_ff @(posedge clk) begin
    if (push) begin
      entry[wr_ptr] <= push_item;
    end
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      wr_ptr <= 1'b0;
      rd_ptr <= 1'b0;
      count  <= 2'd0;
    end else begin
      if (push) begin
        wr_ptr <= ~wr_ptr;
      end
      if (pop) begin
        rd_ptr <= ~rd_ptr;
      end
      if (push && !pop) begin
        count <= count + 2'd1;
      end else if (pop && !push) begin
        count <= count - 2'd1;
      end
    end
  end

endmodule

// ===== rtl/core/one_wire_master_sensor_read.sv =====
// Top level of the one-wire bus master with temperature sensor sequence.
// Depends on owm_pkg, owm_cfg_regs, owm_step and owm_out_buf.
//
// Each request on the slave stream is one microsecond tick: an optional
// command, a byte to send and the sampled bus level. For every tick the
// master stream delivers exactly one result request: whether to pull the
// bus low on that tick, the busy and done flags, the presence flag, the
// last byte read and the last raw temperature word (12.4 format).
// Commands: reset with presence detect, write byte, read byte and measure.
// Measure runs reset, skip ROM, convert, the conversion wait, reset, skip
// ROM, read scratchpad and two byte reads, least significant byte first.
// The configuration channel writes the seven timing registers; it is always
// ready and should be used only while the master is idle.
// A tick accepted is held in the input register, worked through the
// sequencer and written into the result queue, which raises tvalid.
// The master takes one tick per cycle while the result queue has room.
// A two-entry result queue absorbs receiver stalls; once it and the input
// register are full, s_axis_tready falls until a result is taken again.
// Reset clears the queue, the sequencer to idle and the registers to their
// default timings (480, 80, 400, 1, 60, 2 and 200000 ticks).
module one_wire_master_sensor_read (
  input  logic                          clk,
  input  logic                          rst,
  // Tick requests. tdata fields from bit 0: cmd[2:0], tx_byte[10:3],
  // line_level[11], zero padding[15:12].
  input  logic                          s_axis_tvalid,
  output logic                          s_axis_tready,
  input  logic [owm_pkg::IN_W-1:0]      s_axis_tdata,
  // Result requests. tdata fields from bit 0: drive_low[0], busy_res[1],
  // done_res[2], presence[3], rx_byte[11:4], temperature_raw[27:12],
  // zero padding[31:28].
  output logic                          m_axis_tvalid,
  input  logic                          m_axis_tready,
  output logic [owm_pkg::OUT_W-1:0]     m_axis_tdata,
  // Configuration writes.
  input  logic                          cfg_valid,
  output logic                          cfg_ready,
  input  logic [owm_pkg::CFG_IDX_W-1:0] cfg_index,
  input  logic [owm_pkg::CFG_W-1:0]     cfg_data
);

  owm_pkg::cfg_t      cfg;
  owm_pkg::in_item_t  in_q;
  logic               in_q_valid;
  owm_pkg::out_item_t step_result;
  owm_pkg::out_item_t head;
  logic               buf_full;
  logic               fire;
  logic               s_accept;

  assign cfg_ready = 1'b1;

  owm_cfg_regs u_cfg (
    .clk      (clk),
    .rst      (rst),
    .wr_en    (cfg_valid && cfg_ready),
    .wr_index (cfg_index),
    .wr_data  (cfg_data),
    .cfg      (cfg)
  );

  // The input register moves on whenever the queue has room; a new tick can
  // enter in the same cycle as the held one is processed.
  assign fire          = in_q_valid && !buf_full;
  assign s_axis_tready = !in_q_valid || !buf_full;
  assign s_accept      = s_axis_tvalid && s_axis_tready;

  always_ff @(posedge clk) begin
    if (rst) begin
      in_q_valid <= 1'b0;
    end else if (s_accept) begin
      in_q_valid <= 1'b1;
    end else if (fire) begin
      in_q_valid <= 1'b0;
    end
  end

  always_ff @(posedge clk) begin
    if (s_accept) begin
      in_q.cmd        <= s_axis_tdata[2:0];
      in_q.tx_byte    <= s_axis_tdata[10:3];
      in_q.line_level <= s_axis_tdata[11];
    end
  end

  owm_step u_step (
    .clk    (clk),
    .rst    (rst),
    .fire   (fire),
    .tick   (in_q),
    .cfg    (cfg),
    .result (step_result)
  );

  owm_out_buf u_out (
    .clk       (clk),
    .rst       (rst),
    .push      (fire),
    .push_item (step_result),
    .full      (buf_full),
    .valid     (m_axis_tvalid),
    .ready     (m_axis_tready),
    .head      (head)
  );

  assign m_axis_tdata = {4'd0, head.temperature_raw, head.rx_byte, head.presence,
                         head.done_res, head.busy_res, head.drive_low};

endmodule

// ===== rtl/core/owm_checker.sv =====
// Port-level checks of the one-wire bus master, bound to the top level.
// Depends on the port list of one_wire_master_sensor_read.
module owm_checker (
  input logic                      clk,
  input logic                      rst,
  input logic                      s_axis_tready,
  input logic                      m_axis_tvalid,
  input logic                      m_axis_tready,
  input logic [owm_pkg::OUT_W-1:0] m_axis_tdata
);

  // A cleared block offers no result on the cycle after reset.
  a_reset_empty: assert property (@(posedge clk) rst |=> !m_axis_tvalid)
    else $error("result offered straight after reset");

  // Backpressure only comes from results waiting at the output.
  a_stall_source: assert property (@(posedge clk) disable iff (rst)
    !s_axis_tready |-> m_axis_tvalid)
    else $error("input stalled with no result waiting");

  // A command can only complete on a busy tick.
  a_done_busy: assert property (@(posedge clk) disable iff (rst)
    m_axis_tvalid && m_axis_tdata[2] |-> m_axis_tdata[1])
    else $error("done without busy");

  // The bus is only pulled low while a command runs.
  a_drive_busy: assert property (@(posedge clk) disable iff (rst)
    m_axis_tvalid && m_axis_tdata[0] |-> m_axis_tdata[1])
    else $error("bus driven while idle");

  // A stalled result holds.
  a_out_hold: assert property (@(posedge clk) disable iff (rst)
    m_axis_tvalid && !m_axis_tready |=> m_axis_tvalid && $stable(m_axis_tdata))
    else $error("stalled result changed");

endmodule

bind one_wire_master_sensor_read owm_checker u_owm_checker (
  .clk           (clk),
  .rst           (rst),
  .s_axis_tready (s_axis_tready),
  .m_axis_tvalid (m_axis_tvalid),
  .m_axis_tready (m_axis_tready),
  .m_axis_tdata  (m_axis_tdata)
);
